// ----- sv/brge_pkg.sv -----
// Shared types and constants of the bitmap run-length gamma encoder.
package brge_pkg;

  // Header field width and run counter width.
  localparam int unsigned HDR_BITS = 8;
  localparam int unsigned RUN_W    = 16;

  // Longest bit string one pixel can produce: a full run code plus a unit run code.
  localparam int unsigned SEG_W = 28;
  localparam int unsigned LEN_W = 5;

  // Configuration register indexes.
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // Reset value of both image dimensions.
  localparam logic [8:0] DIM_RESET = 9'd8;

  // One packing request from the front to the back.
  typedef struct packed {
    logic [SEG_W-1:0] bits;
    logic [LEN_W-1:0] len;
    logic             last;
  } seg_t;

  // One finished output byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } obyte_t;

endpackage

// ----- sv/bitmap_rle_gamma_encoder_core.sv -----
// Top level of the bitmap run-length gamma encoder.
// Pixels enter one per cycle while in_full is low. The front end classifies each pixel in
// the cycle it arrives and queues a bit string only at a header, a colour change or the
// final pixel; pixels inside a run queue nothing. The back-end packer loads one queued
// string, moves it into bytes, one byte per cycle while the output queue is not full,
// and only then takes the next; one string touches at most five bytes.
// The packer is what sets the sustained rate on images with many short runs; the front
// queue of 2**FQ_ADDR_W entries and the output queue absorb bursts between the two.
module bitmap_rle_gamma_encoder_core #(
  parameter int unsigned FQ_ADDR_W = 2,
  parameter int unsigned OQ_ADDR_W = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata,
  input  logic       in_push,
  input  logic       in_pixel,
  output logic       in_full,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  logic                 accept;
  logic                 fq_push;
  brge_pkg::seg_t       fq_wdata;
  brge_pkg::seg_t       fq_rdata;
  logic                 fq_empty;
  logic                 fq_pop;
  logic                 oq_push;
  logic                 oq_full;
  brge_pkg::obyte_t     oq_wdata;
  brge_pkg::obyte_t     oq_rdata;

  assign accept = in_push && !in_full;

  // Run tracking and classification.
  brge_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pixel     (in_pixel),
    .seg_valid (fq_push),
    .seg       (fq_wdata)
  );

  // Queue between classification and packing.
  brge_fifo #(
    .W      ($bits(brge_pkg::seg_t)),
    .ADDR_W (FQ_ADDR_W)
  ) u_fq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (in_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  // Bit packer.
  brge_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_empty (fq_empty),
    .seg       (fq_rdata),
    .seg_pop   (fq_pop),
    .ob_full   (oq_full),
    .ob_push   (oq_push),
    .ob        (oq_wdata)
  );

  // Output byte queue.
  brge_fifo #(
    .W      ($bits(brge_pkg::obyte_t)),
    .ADDR_W (OQ_ADDR_W)
  ) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty)
  );

  assign out_byte      = oq_rdata.data;
  assign out_last_byte = oq_rdata.last;

endmodule

// ----- sv/brge_fifo.sv -----
// Small first-word-fall-through queue built from registers.
module brge_fifo #(
  parameter int unsigned W      = 8,
  parameter int unsigned ADDR_W = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [W-1:0]      mem_r [DEPTH];
  logic [ADDR_W-1:0] wr_ptr_r;
  logic [ADDR_W-1:0] rd_ptr_r;
  logic [ADDR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == (ADDR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Storage is written only on an accepted request.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- sv/brge_front.sv -----
// Front end: tracks runs over the image and yields the bit strings to pack.
module brge_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [8:0]            cfg_wdata,
  input  logic                  accept,
  input  logic                  pixel,
  output logic                  seg_valid,
  output brge_pkg::seg_t        seg
);

  typedef struct packed {
    logic [25:0] val;
    logic [4:0]  len;
  } code_t;

  logic [8:0]                    width_r;
  logic [8:0]                    height_r;
  logic [15:0]                   pix_cnt_r;
  logic                          colour_r;
  logic [brge_pkg::RUN_W-1:0]    run_n_r;

  logic [8:0]                    w_cl;
  logic [8:0]                    h_cl;
  logic [17:0]                   area;
  logic [15:0]                   last_index;
  logic                          first_px;
  logic                          last_px;
  logic                          same_px;
  logic [brge_pkg::RUN_W-1:0]    n_inc;
  logic [brge_pkg::RUN_W-1:0]    code_n;
  code_t                         code;

  // Gamma-style run code: (b-1)/2 zeros, a one, then n in b bits, first bit lowest.
  function automatic code_t run_code(input logic [brge_pkg::RUN_W-1:0] n);
    code_t      c;
    logic [4:0] blen;
    logic [4:0] b;
    logic [4:0] z;
    blen = '0;
    for (int i = 0; i < brge_pkg::RUN_W; i++) begin
      if (n[i]) begin
        blen = 5'(i + 1);
      end
    end
    b     = blen | 5'd1;
    z     = b >> 1;
    c.val = 26'({n, 1'b1}) << z;
    c.len = z + 5'd1 + b;
    return c;
  endfunction

  // Dimensions outside 1..256 act as the nearest bound.
  always_comb begin
    w_cl = width_r;
    if (width_r == 9'd0) begin
      w_cl = 9'd1;
    end else if (width_r > 9'd256) begin
      w_cl = 9'd256;
    end
    h_cl = height_r;
    if (height_r == 9'd0) begin
      h_cl = 9'd1;
    end else if (height_r > 9'd256) begin
      h_cl = 9'd256;
    end
  end

  assign area       = w_cl * h_cl;
  assign last_index = 16'(area - 18'd1);
  assign first_px   = (pix_cnt_r == 16'd0);
  assign last_px    = (pix_cnt_r >= last_index);
  assign same_px    = (pixel == colour_r);
  assign n_inc      = (run_n_r == {brge_pkg::RUN_W{1'b1}}) ? run_n_r : run_n_r + 1'b1;
  assign code_n     = same_px ? n_inc : run_n_r;
  assign code       = run_code(code_n);

  // Build the bit string for this pixel; a unit run code is the two bits one then zero.
  always_comb begin
    seg.last  = last_px;
    seg.bits  = '0;
    seg.len   = '0;
    seg_valid = 1'b0;
    if (first_px) begin
      seg.bits  = brge_pkg::SEG_W'({2'b01, pixel, 8'(h_cl - 9'd1), 8'(w_cl - 9'd1)});
      seg.len   = last_px ? 5'd19 : 5'd17;
      if (!last_px) begin
        seg.bits = brge_pkg::SEG_W'({pixel, 8'(h_cl - 9'd1), 8'(w_cl - 9'd1)});
      end
      seg_valid = accept;
    end else if (same_px) begin
      seg.bits  = brge_pkg::SEG_W'(code.val);
      seg.len   = code.len;
      seg_valid = accept && last_px;
    end else begin
      seg.bits  = brge_pkg::SEG_W'(code.val);
      seg.len   = code.len;
      if (last_px) begin
        seg.bits = seg.bits | (brge_pkg::SEG_W'(1) << code.len);
        seg.len  = code.len + 5'd2;
      end
      seg_valid = accept;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= brge_pkg::DIM_RESET;
      height_r <= brge_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        brge_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        brge_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Run tracking across the image.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r <= '0;
      colour_r  <= 1'b0;
      run_n_r   <= '0;
    end else if (accept) begin
      if (last_px) begin
        pix_cnt_r <= '0;
        colour_r  <= 1'b0;
        run_n_r   <= '0;
      end else begin
        pix_cnt_r <= pix_cnt_r + 16'd1;
        if (first_px || !same_px) begin
          colour_r <= pixel;
          run_n_r  <= '0;
        end else begin
          run_n_r <= n_inc;
        end
      end
    end
  end

endmodule

// ----- sv/brge_back.sv -----
// Back end: packs queued bit strings into bytes, first bit lowest, and pads the image end.
module brge_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                seg_empty,
  input  brge_pkg::seg_t      seg,
  output logic                seg_pop,
  input  logic                ob_full,
  output logic                ob_push,
  output brge_pkg::obyte_t    ob
);

  logic                        busy_r;
  logic [brge_pkg::SEG_W-1:0]  sh_r;
  logic [brge_pkg::LEN_W-1:0]  rem_r;
  logic                        lst_r;
  logic [7:0]                  acc_r;
  logic [2:0]                  pos_r;

  logic [3:0]                  room;
  logic [3:0]                  k;
  logic [3:0]                  fill;
  logic [7:0]                  mask;
  logic [7:0]                  acc_new;
  logic                        fin;
  logic                        emit;
  logic                        step;

  assign seg_pop = !busy_r && !seg_empty;
  assign step    = busy_r && !ob_full;

  // Take as many bits as fit in the partial byte this cycle.
  always_comb begin
    room    = 4'd8 - 4'(pos_r);
    k       = (rem_r < 5'(room)) ? 4'(rem_r) : room;
    mask    = 8'((9'd1 << k) - 9'd1);
    acc_new = acc_r | 8'((sh_r[7:0] & mask) << pos_r);
    fill    = 4'(pos_r) + k;
    fin     = (rem_r == 5'(k));
    emit    = (fill == 4'd8) || (fin && lst_r);
    ob.data = acc_new;
    ob.last = fin && lst_r;
    ob_push = step && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      acc_r  <= '0;
      pos_r  <= '0;
    end else if (seg_pop) begin
      busy_r <= 1'b1;
    end else if (step) begin
      if (fin) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        acc_r <= '0;
        pos_r <= '0;
      end else begin
        acc_r <= acc_new;
        pos_r <= fill[2:0];
      end
    end
  end

  // Request payload being shifted out.
  always_ff @(posedge clk) begin
    if (seg_pop) begin
      sh_r  <= seg.bits;
      rem_r <= seg.len;
      lst_r <= seg.last;
    end else if (step) begin
      sh_r  <= sh_r >> k;
      rem_r <= rem_r - 5'(k);
    end
  end

endmodule

// ----- tb/bitmap_rle_gamma_encoder_core_tb.sv -----
// Self-checking testbench for the bitmap run-length gamma encoder core.
`timescale 1ns / 1ps

module bitmap_rle_gamma_encoder_core_tb;

  localparam int unsigned ITEM_TARGET  = 470;     // no new phase starts once this many pixels went in
  localparam int unsigned QUIET_AT     = 420;     // no idling on either side after this point
  localparam int unsigned HOLD_AT      = 120;     // long receiver hold-off starts after this
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 40;      // front queue plus packer latency, with margin
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Predicts the compressed byte stream from the accepted pixels and checks it.
  class rle_gamma_scoreboard;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [15:0] pix_idx;
    logic        run_bit;
    logic [15:0] run_len_m1;
    logic [7:0]  acc;
    logic [2:0]  fill;
    brge_pkg::obyte_t expected_bytes[$];
    int          errors;

    function new();
      width_reg  = brge_pkg::DIM_RESET;
      height_reg = brge_pkg::DIM_RESET;
      pix_idx    = '0;
      run_bit    = 1'b0;
      run_len_m1 = '0;
      acc        = '0;
      fill       = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [8:0] val);
      if (idx == brge_pkg::CFG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    // A zero dimension acts as one, anything above 256 acts as 256.
    function int unsigned clamp_dim(logic [8:0] v);
      if (v == 9'd0) return 1;
      if (v > 9'h100) return 256;
      return v;
    endfunction

    function int unsigned image_pixels();
      return clamp_dim(width_reg) * clamp_dim(height_reg);
    endfunction

    function bit mid_image();
      return pix_idx != 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // Bits fill each byte from the least significant end.
    function void put_bit(logic b);
      brge_pkg::obyte_t nb;
      acc[fill] = b;
      if (fill == 3'd7) begin
        nb.data = acc;
        nb.last = 1'b0;
        expected_bytes.push_back(nb);
        acc  = '0;
        fill = '0;
      end else begin
        fill = fill + 3'd1;
      end
    endfunction

    function void put_value(logic [31:0] v, int unsigned nbits);
      int unsigned i;
      for (i = 0; i < nbits; i++) put_bit(v[i]);
    endfunction

    // Gamma-style run code: code width grows by two while it cannot hold n.
    function void put_run(logic [15:0] n);
      int unsigned b;
      b = 1;
      while (b < 31 && (32'd1 << b) <= n) b += 2;
      put_value(32'd0, (b - 1) / 2);
      put_bit(1'b1);
      put_value({16'd0, n}, b);
    endfunction

    function void note_pixel(logic px);
      int unsigned last_idx;
      last_idx = image_pixels() - 1;
      if (pix_idx == 0) begin
        // First pixel of an image: header, then the colour of the first run.
        put_value(clamp_dim(width_reg) - 1, brge_pkg::HDR_BITS);
        put_value(clamp_dim(height_reg) - 1, brge_pkg::HDR_BITS);
        put_bit(px);
        run_bit    = px;
        run_len_m1 = '0;
      end else if (px == run_bit) begin
        if (run_len_m1 != 16'hFFFF) run_len_m1 = run_len_m1 + 16'd1;
      end else begin
        put_run(run_len_m1);
        run_bit    = px;
        run_len_m1 = '0;
      end

      // The image ends at the first pixel at or past the current total; a dimension
      // change in the middle of an image can move that point backward.
      if (pix_idx >= last_idx) begin
        put_run(run_len_m1);
        while (fill != 0) put_bit(1'b0);
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        pix_idx    = '0;
        run_bit    = 1'b0;
        run_len_m1 = '0;
      end else begin
        pix_idx = pix_idx + 16'd1;
      end
    endfunction

    task report(string msg);
      if (errors < 100) $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] data, logic last);
      brge_pkg::obyte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %02h (last=%0b) with nothing expected", data, last));
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data)
        report($sformatf("out_byte %02h, expected %02h", data, want.data));
      if (last !== want.last)
        report($sformatf("out_last_byte %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [8:0] cfg_wdata;
  logic       in_push;
  logic       in_pixel;
  logic       in_full;
  logic       out_pop;
  logic       out_empty;
  logic [7:0] out_byte;
  logic       out_last_byte;

  rle_gamma_scoreboard sb = new();
  int unsigned pixels_sent = 0;
  int unsigned cycle_count = 0;

  bitmap_rle_gamma_encoder_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_pixel     (in_pixel),
    .in_full      (in_full),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one pixel and hold the request until the core takes it.
  task automatic send_pixel(input logic px);
    if (pixels_sent < QUIET_AT && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_full);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  // Send count pixels as runs of random length, or as plain noise.
  task automatic send_runs(input int unsigned count, input bit noisy);
    logic        colour;
    int unsigned run;
    int unsigned left;
    colour = 1'($urandom_range(0, 1));
    left   = count;
    while (left > 0) begin
      if (noisy) begin
        run = 1;
      end else begin
        case ($urandom_range(0, 9))
          0:       run = $urandom_range(21, 300);
          1, 2:    run = $urandom_range(4, 20);
          default: run = $urandom_range(1, 3);
        endcase
      end
      if (run > left) run = left;
      repeat (run) send_pixel(noisy ? 1'($urandom_range(0, 1)) : colour);
      left -= run;
      colour = ~colour;
    end
  endtask

  // Stop offering pixels until every predicted byte is back and the core has gone quiet.
  task automatic settle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both dimensions while the core is idle.
  task automatic set_dims(input logic [8:0] w, input logic [8:0] h);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= brge_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    sb.set_reg(brge_pkg::CFG_IMAGE_WIDTH, w);
    cfg_index <= brge_pkg::CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    sb.set_reg(brge_pkg::CFG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // Result side: accept bytes, with random short stalls and one long hold-off.
  initial begin : result_sink
    int unsigned gap_left;
    int unsigned hold_left;
    bit          held;
    gap_left  = 0;
    hold_left = 0;
    held      = 1'b0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_byte(out_byte, out_last_byte);
      if (!held && pixels_sent >= HOLD_AT && sb.mid_image()) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_pop <= 1'b0;
      end else if (pixels_sent < QUIET_AT && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 3);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Main stimulus.
  initial begin : stimulus
    logic        pattern[6];
    logic [8:0]  w;
    logic [8:0]  h;
    bit          big;
    pattern = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= brge_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    in_push   <= 1'b0;
    in_pixel  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One image at the reset dimensions.
    send_runs(sb.image_pixels(), 1'b0);

    // Single-pixel images back to back, then zero dimensions that act as one.
    set_dims(9'd1, 9'd1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    set_dims(9'd0, 9'd0);
    send_pixel(1'b1);

    // Small image with runs of three, two and one.
    set_dims(9'd3, 9'd2);
    foreach (pattern[i]) send_pixel(pattern[i]);

    // Largest header, then shrink the image under the running one so it ends early.
    set_dims(9'd256, 9'd400);
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    set_dims(9'd2, 9'd1);
    send_pixel(1'b0);

    // A full-width single-row image of noise with an over-range width value; its many
    // colour changes fill both queues while the receiver holds off.
    set_dims(9'd511, 9'd1);
    send_runs(sb.image_pixels(), 1'b1);

    // Random phases: mostly small images, a few full-width or full-height lines, some cut short.
    while (pixels_sent < ITEM_TARGET) begin
      big = 1'b1;
      case ($urandom_range(0, 11))
        0: begin
          w = $urandom_range(0, 1) ? 9'd300 : 9'd256;
          h = $urandom_range(0, 1);
        end
        1: begin
          w = $urandom_range(0, 1);
          h = $urandom_range(0, 1) ? 9'd256 : 9'd400;
        end
        default: begin
          w   = $urandom_range(0, 9);
          h   = $urandom_range(1, 9);
          big = 1'b0;
        end
      endcase
      set_dims(w, h);
      repeat (big ? 1 : $urandom_range(1, 3))
        send_runs(sb.image_pixels(), $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 4) == 0)
        send_runs($urandom_range(1, sb.image_pixels()), 1'b0);
    end

    settle();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
